/* sv/btd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package btd_pkg;

  // entry count and capacity width; capacity never exceeds 31, so neither does the count
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  // APB register map (word index = paddr[PADDR_W-1:2])
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    REQ_PUSH_BOTTOM = 2'd0,
    REQ_PUSH_TOP    = 2'd1,
    REQ_POP_BOTTOM  = 2'd2,
    REQ_POP_TOP     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

endpackage

`default_nettype wire

/* sv/btd_ring.sv */
`timescale 1ns / 1ps
`default_nettype none

module btd_ring #(
  parameter int DEPTH        = 16,
  parameter int HANDLE_WIDTH = 32,
  parameter int IDX_W        = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [IDX_W-1:0]        waddr,
  input  wire logic [HANDLE_WIDTH-1:0] wfn,
  input  wire logic [HANDLE_WIDTH-1:0] wargs,
  input  wire logic                    re,
  input  wire logic [IDX_W-1:0]        raddr,
  output logic      [HANDLE_WIDTH-1:0] rfn,
  output logic      [HANDLE_WIDTH-1:0] rargs
);

  logic [HANDLE_WIDTH-1:0] function_store [DEPTH];
  logic [HANDLE_WIDTH-1:0] args_store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      function_store[waddr] <= wfn;
      args_store[waddr]     <= wargs;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rfn   <= function_store[raddr];
      rargs <= args_store[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/btd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module btd_ctrl
  import btd_pkg::*;
#(
  parameter int DEPTH        = 16,
  parameter int HANDLE_WIDTH = 32,
  parameter int IDX_W        = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [CNT_W-1:0]        capacity,
  // request side
  input  wire logic                    req_valid,
  output logic                         req_ready,
  input  wire logic [1:0]              req_type,
  input  wire logic [HANDLE_WIDTH-1:0] task_function,
  input  wire logic [HANDLE_WIDTH-1:0] task_args,
  // result side
  output logic                         res_valid,
  input  wire logic                    res_ready,
  output logic [1:0]                   status,
  output logic [HANDLE_WIDTH-1:0]      popped_function,
  output logic [HANDLE_WIDTH-1:0]      popped_args,
  output logic                         is_empty,
  output logic [CNT_W-1:0]             entry_count,
  // ring memory
  output logic                         mem_we,
  output logic [IDX_W-1:0]             mem_waddr,
  output logic                         mem_re,
  output logic [IDX_W-1:0]             mem_raddr,
  input  wire logic [HANDLE_WIDTH-1:0] mem_rfn,
  input  wire logic [HANDLE_WIDTH-1:0] mem_rargs
);

  localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(DEPTH);

  state_t state, state_next;

  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;

  req_t             req;
  logic             is_push, missing, full, empty, grant;
  status_t          code;
  logic [CNT_W-1:0] offset;
  logic [SUM_W-1:0] sum;
  logic [IDX_W-1:0] slot_bot, head_dec, head_inc, slot;
  logic             out_free, accept, load_now, load_read;

  // decode
  always_comb begin
    req      = req_t'(req_type);
    is_push  = (req == REQ_PUSH_BOTTOM) || (req == REQ_PUSH_TOP);
    missing  = (task_function == '0) || (task_args == '0);
    full     = (count >= capacity) || (32'(count) >= 32'(DEPTH));
    empty    = (count == '0);
    if (is_push) begin
      grant = !missing && !full;
      code  = missing ? STAT_MISSING : (full ? STAT_FULL : STAT_DONE);
    end else begin
      grant = !empty;
      code  = empty ? STAT_EMPTY : STAT_DONE;
    end

    // bottom slot: head + count for a push, head + count - 1 for a pop (mod DEPTH)
    offset   = (req == REQ_PUSH_BOTTOM) ? count : count - CNT_W'(1);
    sum      = SUM_W'(head) + SUM_W'(offset);
    slot_bot = (sum >= DEPTH_S) ? IDX_W'(sum - DEPTH_S) : IDX_W'(sum);
    head_dec = (head == '0) ? LAST_SLOT : head - IDX_W'(1);
    head_inc = (head == LAST_SLOT) ? '0 : head + IDX_W'(1);

    case (req)
      REQ_PUSH_BOTTOM: slot = slot_bot;
      REQ_PUSH_TOP:    slot = head_dec;
      REQ_POP_BOTTOM:  slot = slot_bot;
      REQ_POP_TOP:     slot = head;
      default:         slot = head;
    endcase

    head_next  = head;
    count_next = count;
    if (grant) begin
      if (is_push) begin
        count_next = count + CNT_W'(1);
      end else begin
        count_next = count - CNT_W'(1);
      end
      if (req == REQ_PUSH_TOP) begin
        head_next = head_dec;
      end else if (req == REQ_POP_TOP) begin
        head_next = head_inc;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !is_push && grant) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_free  = !res_valid || res_ready;
    req_ready = (state == ST_IDLE) && out_free;
    accept    = req_valid && req_ready;
    mem_we    = accept && is_push && grant;
    mem_waddr = slot;
    mem_re    = accept && !is_push && grant;
    mem_raddr = slot;
    // pushes and refused requests produce their result at once; pops after the read
    load_now  = accept && !(!is_push && grant);
    load_read = (state == ST_READ) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        head  <= head_next;
        count <= count_next;
      end
      if (load_now || load_read) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      status          <= code;
      popped_function <= '0;
      popped_args     <= '0;
      is_empty        <= (count_next == '0);
      entry_count     <= count_next;
    end else if (load_read) begin
      status          <= STAT_DONE;
      popped_function <= mem_rfn;
      popped_args     <= mem_rargs;
      is_empty        <= (count == '0);
      entry_count     <= count;
    end
  end

endmodule

`default_nettype wire

/* sv/bounded_task_deque.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of task entries (function handle, argument handle) for a
// work-stealing scheduler. The entries sit in a ring memory of DEPTH slots with a head
// index and a count. Requests arrive on s_* with the request type in s_tuser; every
// request yields one result on m_* with the status in m_tuser. Pushes, and any refused
// request, load their result straight into the output register; a successful pop first
// reads the entry from a synchronous memory and loads it from the ST_READ state. A new
// request is taken when idle and the output register is free or being drained. Capacity
// is an APB register at byte address 0 (reset 16, taken as min(capacity, DEPTH));
// lowering it below the current count keeps the entries and only refuses pushes.
module bounded_task_deque
  import btd_pkg::*;
#(
  parameter int DEPTH        = 16,
  parameter int HANDLE_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // APB configuration
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [PADDR_W-1:0]       paddr,
  input  wire logic [PDATA_W-1:0]       pwdata,
  output logic      [PDATA_W-1:0]       prdata,
  output logic                          pready,
  // request stream
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // s_tdata: task_function, task_args, zero padding
  input  wire logic [((2*HANDLE_WIDTH+7)/8)*8-1:0] s_tdata,
  // s_tuser: req_type
  input  wire logic [1:0]               s_tuser,
  // result stream
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // m_tdata: popped_function, popped_args, is_empty, entry_count, zero padding
  output logic [((2*HANDLE_WIDTH+1+CNT_W+7)/8)*8-1:0] m_tdata,
  // m_tuser: status
  output logic [1:0]                    m_tuser
);

  localparam int IDX_W       = $clog2(DEPTH);
  localparam int OUT_TDATA_W = ((2*HANDLE_WIDTH+1+CNT_W+7)/8)*8;

  logic [CNT_W-1:0]        capacity;
  logic                    cfg_wr;

  logic [HANDLE_WIDTH-1:0] popped_function, popped_args;
  logic                    is_empty;
  logic [CNT_W-1:0]        entry_count;

  logic                    mem_we, mem_re;
  logic [IDX_W-1:0]        mem_waddr, mem_raddr;
  logic [HANDLE_WIDTH-1:0] mem_rfn, mem_rargs;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_CAPACITY)) begin
      capacity <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[PADDR_W-1:2] == REG_CAPACITY) begin
      prdata = PDATA_W'(capacity);
    end else begin
      prdata = '0;
    end
  end

  btd_ctrl #(
    .DEPTH        (DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .capacity        (capacity),
    .req_valid       (s_tvalid),
    .req_ready       (s_tready),
    .req_type        (s_tuser),
    .task_function   (s_tdata[HANDLE_WIDTH-1:0]),
    .task_args       (s_tdata[2*HANDLE_WIDTH-1:HANDLE_WIDTH]),
    .res_valid       (m_tvalid),
    .res_ready       (m_tready),
    .status          (m_tuser),
    .popped_function (popped_function),
    .popped_args     (popped_args),
    .is_empty        (is_empty),
    .entry_count     (entry_count),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rfn         (mem_rfn),
    .mem_rargs       (mem_rargs)
  );

  btd_ring #(
    .DEPTH        (DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH),
    .IDX_W        (IDX_W)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wfn   (s_tdata[HANDLE_WIDTH-1:0]),
    .wargs (s_tdata[2*HANDLE_WIDTH-1:HANDLE_WIDTH]),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rfn   (mem_rfn),
    .rargs (mem_rargs)
  );

  assign m_tdata = OUT_TDATA_W'({entry_count, is_empty, popped_args, popped_function});

endmodule

`default_nettype wire

/* tb/bounded_task_deque_tb.sv */
`timescale 1ns / 1ps

module bounded_task_deque_tb;
  import btd_pkg::*;

  localparam int RING_SLOTS = 16;
  localparam logic [PADDR_W-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR = 3'd4;
  localparam int GAP_PCT = 18;

  typedef struct {
    status_t     status;
    logic [31:0] popped_function;
    logic [31:0] popped_args;
    logic        is_empty;
    logic [4:0]  entry_count;
  } deque_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // s_tdata: task_function, task_args
  logic [63:0]        s_tdata = '0;
  // s_tuser: req_type
  logic [1:0]         s_tuser = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // m_tdata: popped_function, popped_args, is_empty, entry_count, padding
  logic [71:0]        m_tdata;
  // m_tuser: status
  logic [1:0]         m_tuser;

  // shadow deque
  logic [31:0] ring_function [RING_SLOTS];
  logic [31:0] ring_args [RING_SLOTS];
  logic [3:0]  top_slot = '0;
  logic [4:0]  n_held = '0;
  logic [4:0]  cap_setting = CAP_RESET;

  deque_result_t pending_results[$];
  bit no_gaps = 1'b0;
  int n_errors = 0;
  int n_sent = 0;
  int n_cap_writes = 0;
  int n_done = 0, n_full = 0, n_empty = 0, n_missing = 0;

  bounded_task_deque u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

  always @(negedge clk) begin
    m_tready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
  end

  function automatic deque_result_t apply_request(req_t req, logic [31:0] fn, logic [31:0] ar);
    deque_result_t r;
    logic [4:0] limit;
    logic [3:0] slot;
    r.status = STAT_DONE;
    r.popped_function = '0;
    r.popped_args = '0;
    limit = (cap_setting > RING_SLOTS) ? 5'(RING_SLOTS) : cap_setting;
    if (req == REQ_PUSH_BOTTOM || req == REQ_PUSH_TOP) begin
      if (fn == '0 || ar == '0) begin
        r.status = STAT_MISSING;
      end else if (n_held >= limit) begin
        r.status = STAT_FULL;
      end else begin
        if (req == REQ_PUSH_BOTTOM) begin
          slot = top_slot + n_held[3:0];
        end else begin
          top_slot = top_slot - 4'd1;
          slot = top_slot;
        end
        ring_function[slot] = fn;
        ring_args[slot] = ar;
        n_held = n_held + 5'd1;
      end
    end else begin
      if (n_held == '0) begin
        r.status = STAT_EMPTY;
      end else begin
        if (req == REQ_POP_BOTTOM) begin
          slot = top_slot + 4'(n_held - 5'd1);
        end else begin
          slot = top_slot;
          top_slot = top_slot + 4'd1;
        end
        r.popped_function = ring_function[slot];
        r.popped_args = ring_args[slot];
        n_held = n_held - 5'd1;
      end
    end
    r.is_empty = (n_held == '0);
    r.entry_count = n_held;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result beat, expected none, actual tuser %h tdata %h",
                 $time, m_tuser, m_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("popped_function", want.popped_function, m_tdata[31:0]);
        check_field("popped_args", want.popped_args, m_tdata[63:32]);
        check_field("is_empty", 32'(want.is_empty), 32'(m_tdata[64]));
        check_field("entry_count", 32'(want.entry_count), 32'(m_tdata[69:65]));
        case (want.status)
          STAT_DONE:    n_done++;
          STAT_FULL:    n_full++;
          STAT_EMPTY:   n_empty++;
          STAT_MISSING: n_missing++;
          default:      ;
        endcase
      end
    end
  end

  // valid stays high after the accepting edge; the next call or drain decides
  task automatic send_request(req_t req, logic [31:0] fn, logic [31:0] ar);
    @(negedge clk);
    while (!no_gaps && $urandom_range(0, 99) < GAP_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {ar, fn};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_request(req, fn, ar));
    n_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [PADDR_W-1:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr && addr == CAP_ADDR) begin
      cap_setting = data[4:0];
      n_cap_writes++;
    end
    if (!wr && addr == CAP_ADDR)
      check_field("capacity readback", {27'd0, cap_setting}, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // upper bits of the write data carry noise; only the low five count
  task automatic set_capacity(logic [4:0] cap);
    drain();
    apb_access(1'b1, CAP_ADDR, {27'($urandom), cap});
    apb_access(1'b0, CAP_ADDR, '0);
  endtask

  task automatic test_empty_pops;
    send_request(REQ_POP_BOTTOM, '0, '0);
    send_request(REQ_POP_TOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_missing_handles;
    send_request(REQ_PUSH_BOTTOM, 32'h0, 32'h1234_5678);
    send_request(REQ_PUSH_TOP, 32'hDEAD_BEEF, 32'h0);
    send_request(REQ_PUSH_BOTTOM, 32'h0, 32'h0);
  endtask

  task automatic test_both_ends;
    send_request(REQ_PUSH_BOTTOM, 32'hFFFF_FFFF, 32'h0000_0001);
    send_request(REQ_PUSH_TOP, 32'h8000_0000, 32'h7FFF_FFFF);   // head wraps below slot 0
    send_request(REQ_PUSH_BOTTOM, 32'h0000_0001, 32'hFFFF_FFFF);
    send_request(REQ_POP_TOP, '0, '0);
    send_request(REQ_POP_BOTTOM, '0, '0);
    send_request(REQ_POP_BOTTOM, '0, '0);
    send_request(REQ_POP_TOP, '0, '0);
  endtask

  task automatic test_capacity_limits;
    set_capacity(5'd0);
    send_request(REQ_PUSH_TOP, 32'h5555_5555, 32'hAAAA_AAAA);
    set_capacity(5'd2);
    send_request(REQ_PUSH_BOTTOM, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(REQ_PUSH_TOP, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    send_request(REQ_PUSH_BOTTOM, 32'h1111_1111, 32'h2222_2222);
    // lowered below the held count: entries stay, pushes refused
    set_capacity(5'd1);
    send_request(REQ_PUSH_BOTTOM, 32'h3333_3333, 32'h4444_4444);
    send_request(REQ_POP_TOP, '0, '0);
    send_request(REQ_POP_BOTTOM, '0, '0);
  endtask

  task automatic test_unmapped_register;
    drain();
    apb_access(1'b1, SPARE_ADDR, 32'h0);
    apb_access(1'b0, CAP_ADDR, '0);
    send_request(REQ_PUSH_BOTTOM, 32'h0000_00FF, 32'hFF00_0000);
    send_request(REQ_POP_TOP, '0, '0);
  endtask

  task automatic run_random_phase(int n_items, int push_pct, bit burst);
    req_t req;
    logic [31:0] fn, ar;
    int pick;
    no_gaps = burst;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < push_pct)
        req = $urandom_range(0, 1) ? REQ_PUSH_TOP : REQ_PUSH_BOTTOM;
      else
        req = $urandom_range(0, 1) ? REQ_POP_TOP : REQ_POP_BOTTOM;
      fn = $urandom;
      ar = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 3) fn = '0;
      else if (pick < 6) ar = '0;
      else if (pick < 8) begin
        fn = '0;
        ar = '0;
      end else begin
        if (fn == '0) fn = 32'd1;
        if (ar == '0) ar = 32'd1;
      end
      send_request(req, fn, ar);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic;
    logic [4:0] caps [8] = '{5'd16, 5'd31, 5'd3, 5'd1, 5'd0, 5'd16, 5'd31, 5'd8};
    int push_pcts [8] = '{55, 80, 60, 50, 60, 50, 70, 50};
    for (int p = 0; p < 8; p++) begin
      set_capacity(caps[p]);
      run_random_phase(125, push_pcts[p], p == 5);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_pops();
    test_missing_handles();
    test_both_ends();
    test_capacity_limits();
    test_unmapped_register();
    test_random_traffic();
    drain();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      n_errors++;
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, pending_results.size());
    end
    $display("Sent %0d requests to both ends over %0d capacity writes, empty through full.",
             n_sent, n_cap_writes);
    $display("Outcomes: %0d done, %0d full, %0d empty pops, %0d missing handle.",
             n_done, n_full, n_empty, n_missing);
    if (n_errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
